>>> hdl/vector_distance_metrics_core_macros.svh
// Assertion macros for the vector distance core.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef VECTOR_DISTANCE_METRICS_CORE_MACROS_SVH
`define VECTOR_DISTANCE_METRICS_CORE_MACROS_SVH

// Same-cycle implication.
`define VDM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdm check failed");

// Next-cycle implication.
`define VDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdm check failed");

`endif

>>> hdl/vdm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdm_pkg
// Shared constants, types and helpers of the vector distance core.
// ---------------------------------------------------------------------------
package vdm_pkg;

  localparam int MAX_DIM = 16384;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int ACC_W   = 48;
  localparam int ROOT_W  = ACC_W / 2;
  localparam int STEPS   = ROOT_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int REM_W   = ROOT_W + 3;

  localparam logic [1:0] MET_EUCLID    = 2'd0;
  localparam logic [1:0] MET_INNER     = 2'd1;
  localparam logic [1:0] MET_COSINE    = 2'd2;
  localparam logic [1:0] MET_MANHATTAN = 2'd3;

  localparam logic [ACC_W-1:0] ONE_Q24 = 48'h000001000000;
  localparam logic [ACC_W-1:0] TWO_Q24 = 48'h000002000000;

  typedef struct packed {
    logic [1:0]              metric;
    logic                    overlong;
    logic signed [ACC_W-1:0] main;
    logic [ACC_W-1:0]        norm_a;
    logic [ACC_W-1:0]        norm_b;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQRT_A,
    B_SQRT_B,
    B_MUL,
    B_CMP,
    B_DIV,
    B_EMIT
  } back_state_t;

  // Saturating add of a sign-extended term to a 48-bit accumulator.
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W:0]   term);
    logic [ACC_W:0] sum;
    sum = {acc[ACC_W-1], acc} + term;
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = sum[ACC_W-1:0];
    end
  endfunction

endpackage

>>> hdl/vdm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdm_front
// Accepts element pairs, folds them into saturating accumulators and hands a
// finished vector to the job queue on the last pair.
// ---------------------------------------------------------------------------
module vdm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_a_elem,
  input  logic signed [15:0]   in_b_elem,
  input  logic                 in_last_elem,
  input  logic [1:0]           metric,
  input  vdm_pkg::q_stat_t     q_stat,
  output logic                 push,
  output vdm_pkg::job_t        push_job
);

  logic [vdm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [vdm_pkg::ACC_W-1:0] main_r, main_nxt;
  logic [vdm_pkg::ACC_W-1:0] na_r, na_nxt;
  logic [vdm_pkg::ACC_W-1:0] nb_r, nb_nxt;
  logic                      ovl_r, ovl_nxt;

  logic               accept;
  logic signed [16:0] diff;
  logic signed [33:0] sq_diff;
  logic [16:0]        diff_mag;
  logic signed [31:0] prod_ab, prod_aa, prod_bb;
  logic [vdm_pkg::ACC_W:0] main_term;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign diff     = {in_a_elem[15], in_a_elem} - {in_b_elem[15], in_b_elem};
  assign sq_diff  = diff * diff;
  assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
  assign prod_ab  = in_a_elem * in_b_elem;
  assign prod_aa  = in_a_elem * in_a_elem;
  assign prod_bb  = in_b_elem * in_b_elem;

  always_comb begin
    unique case (metric)
      vdm_pkg::MET_EUCLID:    main_term = 49'(sq_diff);
      vdm_pkg::MET_MANHATTAN: main_term = {32'b0, diff_mag};
      default:                main_term = 49'(prod_ab);
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    main_nxt = main_r;
    na_nxt   = na_r;
    nb_nxt   = nb_r;
    ovl_nxt  = ovl_r;
    if (!ovl_r) begin
      if (cnt_r >= vdm_pkg::CNT_W'(vdm_pkg::MAX_DIM)) begin
        ovl_nxt = 1'b1;
      end else begin
        cnt_nxt  = cnt_r + 1'b1;
        main_nxt = vdm_pkg::sat_add(main_r, main_term);
        na_nxt   = vdm_pkg::sat_add(na_r, 49'(prod_aa));
        nb_nxt   = vdm_pkg::sat_add(nb_r, 49'(prod_bb));
      end
    end
  end

  assign push              = accept && in_last_elem;
  assign push_job.metric   = metric;
  assign push_job.overlong = ovl_nxt;
  assign push_job.main     = main_nxt;
  assign push_job.norm_a   = na_nxt;
  assign push_job.norm_b   = nb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r  <= '0;
      main_r <= '0;
      na_r   <= '0;
      nb_r   <= '0;
      ovl_r  <= 1'b0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      main_r <= main_nxt;
      na_r   <= na_nxt;
      nb_r   <= nb_nxt;
      ovl_r  <= ovl_nxt;
    end
  end

endmodule

>>> hdl/vdm_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdm_fifo
// Two-entry job queue between the accumulating front and the back unit.
// ---------------------------------------------------------------------------
module vdm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vdm_pkg::job_t     push_job,
  input  logic              pop,
  output vdm_pkg::job_t     head_job,
  output vdm_pkg::q_stat_t  q_stat
);

  vdm_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hdl/vdm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdm_back
// Finishes one vector: shared bit-serial square root, one multiply and a
// bit-serial divide for the cosine, then the registered result.
// ---------------------------------------------------------------------------
module vdm_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  vdm_pkg::q_stat_t        q_stat,
  input  vdm_pkg::job_t           head_job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [47:0]      out_distance,
  output logic                    out_status
);

  localparam int AW = vdm_pkg::ACC_W;
  localparam int RW = vdm_pkg::ROOT_W;

  vdm_pkg::back_state_t state_r, state_nxt;
  vdm_pkg::job_t        job_r;

  logic [vdm_pkg::STEP_W-1:0] step_r;
  logic [AW-1:0]              sq_x_r;
  logic [RW-1:0]              sq_root_r, root_nxt, ra_r, rb_r;
  logic [vdm_pkg::REM_W-1:0]  sq_rem_r, rem_shift, rem_nxt, trial;
  logic [AW-1:0]              den_r, mag_r;
  logic [AW:0]                drem_r, drem_shift, drem_nxt;
  logic [RW:0]                q_r, q_nxt;
  logic [AW-1:0]              res_r;

  logic          out_valid_r;
  logic [AW-1:0] out_dist_r;
  logic          out_status_r;

  logic          last_step, out_free, load_out, mag_ge;
  logic          head_direct;
  logic [AW-1:0] head_res;

  assign last_step = step_r == vdm_pkg::STEP_W'(vdm_pkg::STEPS - 1);
  assign out_free  = !out_valid_r || out_ready;
  assign mag_ge    = mag_r >= den_r;

  // One root digit per cycle from the top two bits of the radicand.
  assign rem_shift = {sq_rem_r[vdm_pkg::REM_W-3:0], sq_x_r[AW-1:AW-2]};
  assign trial     = {1'b0, sq_root_r, 2'b01};
  always_comb begin
    if (rem_shift >= trial) begin
      rem_nxt  = rem_shift - trial;
      root_nxt = {sq_root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_shift;
      root_nxt = {sq_root_r[RW-2:0], 1'b0};
    end
  end

  // One quotient bit per cycle.
  assign drem_shift = {drem_r[AW-1:0], 1'b0};
  always_comb begin
    if (drem_shift >= {1'b0, den_r}) begin
      drem_nxt = drem_shift - {1'b0, den_r};
      q_nxt    = {q_r[RW-1:0], 1'b1};
    end else begin
      drem_nxt = drem_shift;
      q_nxt    = {q_r[RW-1:0], 1'b0};
    end
  end

  // Results that need no iteration.
  always_comb begin
    head_direct = 1'b1;
    head_res    = head_job.main;
    if (head_job.overlong) begin
      head_res = '0;
    end else begin
      unique case (head_job.metric)
        vdm_pkg::MET_EUCLID: begin
          head_res    = '0;
          head_direct = head_job.main[AW-1] || head_job.main == '0;
        end
        vdm_pkg::MET_COSINE: begin
          head_res    = vdm_pkg::ONE_Q24;
          head_direct = head_job.norm_a == '0 || head_job.norm_b == '0;
        end
        default: head_res = head_job.main;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vdm_pkg::B_IDLE:
        if (!q_stat.empty) begin
          state_nxt = head_direct ? vdm_pkg::B_EMIT : vdm_pkg::B_SQRT_A;
        end
      vdm_pkg::B_SQRT_A:
        if (last_step) begin
          state_nxt = (job_r.metric == vdm_pkg::MET_EUCLID) ? vdm_pkg::B_EMIT
                                                            : vdm_pkg::B_SQRT_B;
        end
      vdm_pkg::B_SQRT_B:
        if (last_step) begin
          state_nxt = vdm_pkg::B_MUL;
        end
      vdm_pkg::B_MUL: state_nxt = vdm_pkg::B_CMP;
      vdm_pkg::B_CMP: state_nxt = mag_ge ? vdm_pkg::B_EMIT : vdm_pkg::B_DIV;
      vdm_pkg::B_DIV:
        if (last_step) begin
          state_nxt = vdm_pkg::B_EMIT;
        end
      vdm_pkg::B_EMIT:
        if (out_free) begin
          state_nxt = vdm_pkg::B_IDLE;
        end
      default: state_nxt = vdm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_r == vdm_pkg::B_IDLE) && !q_stat.empty;
    load_out = (state_r == vdm_pkg::B_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdm_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      vdm_pkg::B_IDLE: begin
        job_r     <= head_job;
        res_r     <= head_res;
        step_r    <= '0;
        sq_root_r <= '0;
        sq_rem_r  <= '0;
        sq_x_r    <= (head_job.metric == vdm_pkg::MET_COSINE) ? head_job.norm_a
                                                              : head_job.main;
      end
      vdm_pkg::B_SQRT_A, vdm_pkg::B_SQRT_B: begin
        step_r    <= step_r + 1'b1;
        sq_root_r <= root_nxt;
        sq_rem_r  <= rem_nxt;
        sq_x_r    <= {sq_x_r[AW-3:0], 2'b00};
        if (last_step) begin
          step_r    <= '0;
          sq_root_r <= '0;
          sq_rem_r  <= '0;
          sq_x_r    <= job_r.norm_b;
          if (state_r == vdm_pkg::B_SQRT_A) begin
            ra_r  <= root_nxt;
            res_r <= {{(AW-RW){1'b0}}, root_nxt};
          end else begin
            rb_r <= root_nxt;
          end
        end
      end
      vdm_pkg::B_MUL: begin
        den_r <= ra_r * rb_r;
        mag_r <= job_r.main[AW-1] ? AW'(-job_r.main) : job_r.main;
      end
      vdm_pkg::B_CMP: begin
        res_r  <= job_r.main[AW-1] ? vdm_pkg::TWO_Q24 : '0;
        drem_r <= {1'b0, mag_r};
        q_r    <= '0;
        step_r <= '0;
      end
      vdm_pkg::B_DIV: begin
        step_r <= step_r + 1'b1;
        drem_r <= drem_nxt;
        q_r    <= q_nxt;
        if (last_step) begin
          res_r <= job_r.main[AW-1] ? vdm_pkg::ONE_Q24 + AW'(q_nxt)
                                    : vdm_pkg::ONE_Q24 - AW'(q_nxt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dist_r   <= res_r;
      out_status_r <= job_r.overlong;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_status   = out_status_r;

endmodule

>>> hdl/vector_distance_metrics_core.sv
`timescale 1ns / 1ps
// Throughput: one element pair per cycle while the two-entry job queue has room.
// From the last pair to the result: inner product, Manhattan, overlong and trivial
// cases go straight to the output register; Euclidean takes a 24-step square root;
// cosine takes two square roots, a multiply, a compare and, unless |dot| reaches the
// denominator, a 24-step divide, all in the shared back unit.
// Synchronous active-low reset clears the metric, the accumulators and the queue.
// ---------------------------------------------------------------------------
// vector_distance_metrics_core
// Streaming L2 / inner product / cosine / L1 distance over Q4.12 vectors.
// ---------------------------------------------------------------------------
`include "vector_distance_metrics_core_macros.svh"

module vector_distance_metrics_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_a_elem,
  input  logic signed [15:0]  in_b_elem,
  input  logic                in_last_elem,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  out_distance,
  output logic                out_status
);

  logic [1:0]        metric_r;
  logic              push, pop;
  vdm_pkg::job_t     push_job, head_job;
  vdm_pkg::q_stat_t  q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= vdm_pkg::MET_EUCLID;
    end else if (cfg_wr_en) begin
      metric_r <= cfg_wr_data;
    end
  end

  vdm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_elem    (in_a_elem),
    .in_b_elem    (in_b_elem),
    .in_last_elem (in_last_elem),
    .metric       (metric_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  vdm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  vdm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance),
    .out_status   (out_status)
  );

  // The queue must never be written when full or read when empty.
  `VDM_ASSERT_NOW(a_no_push_full, push, !q_stat.full)
  `VDM_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty)
  // An overlong vector always reports a zero distance.
  `VDM_ASSERT_NOW(a_overlong_zero, out_valid && out_status, out_distance == '0)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Streams element pairs into the vector distance core under every metric,
// predicts each distance in a scoreboard and checks the results in order.
// ---------------------------------------------------------------------------
module tb;

  // Keeps the running sums of the open vector and the distances still owed.
  class dist_scoreboard;
    logic [1:0]      metric;
    int unsigned     pair_count;
    longint          main_sum;
    longint          norm_a_sum;
    longint          norm_b_sum;
    bit              too_long;
    longint          owed_dist[$];
    bit              owed_status[$];
    int              errors;

    function new();
      metric = vdm_pkg::MET_EUCLID;
      errors = 0;
      clear_vector();
    endfunction

    function void clear_vector();
      pair_count = 0;
      main_sum = 0;
      norm_a_sum = 0;
      norm_b_sum = 0;
      too_long = 0;
    endfunction

    function longint sat48(longint v);
      longint hi;
      hi = (longint'(1) <<< 47) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = longint'(1) << 46;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint cosine_dist();
      longint unsigned den;
      longint unsigned mag;
      longint unsigned q;
      longint one;
      one = longint'(1) << 24;
      if (norm_a_sum <= 0 || norm_b_sum <= 0) return one;
      den = floor_root(norm_a_sum) * floor_root(norm_b_sum);
      mag = (main_sum < 0) ? -main_sum : main_sum;
      if (mag >= den) begin
        q = one;
      end else begin
        q = 0;
        repeat (24) begin
          mag = mag << 1;
          q = q << 1;
          if (mag >= den) begin
            mag = mag - den;
            q = q | 1;
          end
        end
      end
      return (main_sum < 0) ? one + longint'(q) : one - longint'(q);
    endfunction

    function void note_request(logic signed [15:0] a, logic signed [15:0] b, logic last);
      longint av;
      longint bv;
      longint d;
      longint res_dist;
      av = a;
      bv = b;
      d = av - bv;
      res_dist = 0;
      if (!too_long) begin
        if (pair_count >= vdm_pkg::MAX_DIM) begin
          too_long = 1;
        end else begin
          pair_count++;
          case (metric)
            vdm_pkg::MET_EUCLID:    main_sum = sat48(main_sum + d * d);
            vdm_pkg::MET_MANHATTAN: main_sum = sat48(main_sum + ((d < 0) ? -d : d));
            default:                main_sum = sat48(main_sum + av * bv);
          endcase
          norm_a_sum = sat48(norm_a_sum + av * av);
          norm_b_sum = sat48(norm_b_sum + bv * bv);
        end
      end
      if (!last) return;
      if (!too_long) begin
        case (metric)
          vdm_pkg::MET_EUCLID: res_dist = (main_sum > 0) ? longint'(floor_root(main_sum)) : 0;
          vdm_pkg::MET_COSINE: res_dist = cosine_dist();
          default:             res_dist = main_sum;
        endcase
      end
      owed_dist.push_back(res_dist);
      owed_status.push_back(too_long);
      clear_vector();
    endfunction

    function void check_result(logic signed [47:0] got_dist, logic status);
      logic signed [47:0] want_dist;
      bit want_status;
      if (owed_dist.size() == 0) begin
        $error("unexpected result: distance %0d status %0d", got_dist, status);
        errors++;
        return;
      end
      want_dist = 48'(owed_dist.pop_front());
      want_status = owed_status.pop_front();
      if (got_dist !== want_dist) begin
        $error("distance: expected %0d, got %0d", want_dist, got_dist);
        errors++;
      end
      if (status !== want_status) begin
        $error("status: expected %0d, got %0d", want_status, status);
        errors++;
      end
    endfunction

    function int pending();
      return owed_dist.size();
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_wr_en = 0;
  logic [1:0]         cfg_wr_data = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [15:0] in_a_elem = '0;
  logic signed [15:0] in_b_elem = '0;
  logic               in_last_elem = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [47:0] out_distance;
  logic               out_status;

  dist_scoreboard sb = new();
  bit quiet = 0;
  int stall_left = 0;

  vector_distance_metrics_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_elem    (in_a_elem),
    .in_b_elem    (in_b_elem),
    .in_last_elem (in_last_elem),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance),
    .out_status   (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver side: random stall bursts, none once the run goes quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_distance, out_status);
  end

  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    in_a_elem <= a;
    in_b_elem <= b;
    in_last_elem <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(a, b, last);
  endtask

  // The core must be idle for a metric write, so every result is drained first.
  task automatic set_metric(logic [1:0] m);
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.metric = m;
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    logic signed [15:0] x;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Field extremes under every metric, including a one-pair vector.
    for (int m = 0; m < 4; m++) begin
      set_metric(m[1:0]);
      send_pair(16'sh7FFF, 16'sh8000, 0);
      send_pair(16'sh8000, 16'sh8000, 0);
      send_pair(16'sh0000, 16'sh7FFF, 0);
      send_pair(16'sh7FFF, 16'sh7FFF, 1);
      send_pair(16'sh8000, 16'sh7FFF, 1);
    end
    // Cosine: a zero norm, opposite vectors and identical vectors.
    set_metric(vdm_pkg::MET_COSINE);
    send_pair(16'sh0000, 16'sh1234, 0);
    send_pair(16'sh0000, 16'sh8000, 1);
    send_pair(16'sh1000, -16'sh1000, 0);
    send_pair(16'sh0800, -16'sh0800, 1);
    send_pair(16'sh0F00, 16'sh0F00, 1);
    // Metric switched in the middle of a vector.
    send_pair(16'sh0400, 16'sh0200, 0);
    set_metric(vdm_pkg::MET_EUCLID);
    send_pair(16'sh7000, 16'sh8800, 0);
    set_metric(vdm_pkg::MET_MANHATTAN);
    send_pair(16'sh0001, 16'sh8000, 1);

    sent = 0;
    while (sent < 1750) begin
      if ($urandom_range(0, 5) == 0) set_metric(2'($urandom_range(0, 3)));
      if (sent > 1550) quiet = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        x = pick_elem();
        if ($urandom_range(0, 3) == 0) send_pair(x, x, i == len - 1);
        else send_pair(x, pick_elem(), i == len - 1);
      end
      sent += len;
    end
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("vector_distance_metrics_core verification clean");
    end else begin
      $display("vector_distance_metrics_core verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("vector_distance_metrics_core verification failed");
    $finish;
  end

endmodule
